FILE: rtl/png_chunk_xmp_locator_core_defines.svh
// Assertion macros shared by the PNG XMP locator RTL.
// Every macro assumes clk_i and rst_ni are in scope; no other dependencies.
`ifndef PNG_CHUNK_XMP_LOCATOR_CORE_DEFINES_SVH
`define PNG_CHUNK_XMP_LOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PXL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PXL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pngxmp_pkg.sv
// Shared types, constants and lookup functions for the PNG XMP locator.
// No dependencies.
package pngxmp_pkg;

  localparam int unsigned OffsetBitsDefault = 32;

  localparam int unsigned SigLen    = 8;
  localparam int unsigned HdrLen    = 8;
  localparam int unsigned HdrLenLen = 4;
  localparam int unsigned PfxLen    = 22;
  localparam int unsigned KeyLen    = 18;
  localparam int unsigned CrcLen    = 4;
  localparam int unsigned ChunkOvh  = 12;

  localparam logic [31:0] TypeIend = 32'h49454E44;
  localparam logic [31:0] TypeItxt = 32'h69545874;

  typedef enum logic [2:0] {
    CLS_SIG     = 3'd0,
    CLS_HEADER  = 3'd1,
    CLS_PREFIX  = 3'd2,
    CLS_PAYLOAD = 3'd3,
    CLS_SKIP    = 3'd4,
    CLS_IGNORED = 3'd5
  } byte_class_e;

  typedef enum logic [1:0] {
    ST_PARSING = 2'd0,
    ST_DONE    = 2'd1,
    ST_SIG_ERR = 2'd2
  } parse_status_e;

  typedef struct packed {
    logic strip_enable;
    logic capture_enable;
  } cfg_t;

  typedef struct packed {
    parse_status_e parse_status;
    logic [32:0]   strip_size;
    logic [31:0]   strip_offset;
    logic          strip_valid;
    byte_class_e   byte_class;
  } result_t;

  function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h89;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      3'd7:    val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // XMP keyword followed by its NUL terminator.
  function automatic logic [7:0] xmp_key_byte(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0:    val = 8'h58; // X
      5'd1:    val = 8'h4D; // M
      5'd2:    val = 8'h4C; // L
      5'd3:    val = 8'h3A; // :
      5'd4:    val = 8'h63; // c
      5'd5:    val = 8'h6F; // o
      5'd6:    val = 8'h6D; // m
      5'd7:    val = 8'h2E; // .
      5'd8:    val = 8'h61; // a
      5'd9:    val = 8'h64; // d
      5'd10:   val = 8'h6F; // o
      5'd11:   val = 8'h62; // b
      5'd12:   val = 8'h65; // e
      5'd13:   val = 8'h2E; // .
      5'd14:   val = 8'h78; // x
      5'd15:   val = 8'h6D; // m
      5'd16:   val = 8'h70; // p
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/pngxmp_parser.sv
// Byte-serial PNG chunk walker: parse state and per-byte result logic.
// Depends on pngxmp_pkg and png_chunk_xmp_locator_core_defines.svh.
`include "png_chunk_xmp_locator_core_defines.svh"

module pngxmp_parser #(
  parameter int unsigned OFFSET_BITS = pngxmp_pkg::OffsetBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  pngxmp_pkg::cfg_t    cfg_i,
  output pngxmp_pkg::result_t result_o
);
  import pngxmp_pkg::*;

  typedef enum logic [2:0] {
    PH_SIG     = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PREFIX  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_SKIP    = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [4:0]             fcount_q, fcount_d;
  logic [31:0]            clen_q, clen_d;
  logic [31:0]            ctype_q, ctype_d;
  logic                   match_q, match_d;
  logic [32:0]            left_q, left_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [OFFSET_BITS-1:0] cstart_q, cstart_d;
  logic                   captured_q, captured_d;

  logic [4:0]  fcount_inc;
  logic [32:0] left_dec;
  logic [31:0] payload_len;
  logic [63:0] cstart_wide;
  logic        match_now;
  result_t     res;

  assign fcount_inc  = fcount_q + 5'd1;
  assign left_dec    = (left_q != 33'd0) ? (left_q - 33'd1) : 33'd0;
  assign payload_len = clen_q - 32'(PfxLen);
  assign cstart_wide = 64'(cstart_q);

  always_comb begin
    phase_d    = phase_q;
    fcount_d   = fcount_q;
    clen_d     = clen_q;
    ctype_d    = ctype_q;
    match_d    = match_q;
    left_d     = left_q;
    cstart_d   = cstart_q;
    captured_d = captured_q;
    offset_d   = offset_q + OFFSET_BITS'(1);
    match_now  = match_q;

    res              = '0;
    res.byte_class   = CLS_IGNORED;
    res.parse_status = ST_PARSING;

    case (phase_q)
      PH_SIG: begin
        res.byte_class = CLS_SIG;
        match_now = match_q && (data_byte_i == png_sig_byte(fcount_q[2:0]));
        match_d   = match_now;
        fcount_d  = fcount_inc;
        if (fcount_inc >= 5'(SigLen)) begin
          phase_d  = match_now ? PH_HEADER : PH_ERROR;
          fcount_d = '0;
          match_d  = 1'b1;
        end
      end
      PH_HEADER: begin
        res.byte_class = CLS_HEADER;
        if (fcount_q == 5'd0) begin
          cstart_d = offset_q;
        end
        if (fcount_q < 5'(HdrLenLen)) begin
          clen_d = {clen_q[23:0], data_byte_i};
        end else begin
          ctype_d = {ctype_q[23:0], data_byte_i};
        end
        fcount_d = fcount_inc;
        if (fcount_inc >= 5'(HdrLen)) begin
          fcount_d = '0;
          if (ctype_d == TypeIend) begin
            phase_d = PH_DONE;
          end else if (ctype_d == TypeItxt && clen_q >= 32'(PfxLen)) begin
            phase_d = PH_PREFIX;
            match_d = 1'b1;
          end else begin
            phase_d = PH_SKIP;
            left_d  = {1'b0, clen_q} + 33'(CrcLen);
          end
        end
      end
      PH_PREFIX: begin
        res.byte_class = CLS_PREFIX;
        match_now = match_q &&
                    !(fcount_q < 5'(KeyLen) && data_byte_i != xmp_key_byte(fcount_q));
        match_d   = match_now;
        fcount_d  = fcount_inc;
        if (fcount_inc >= 5'(PfxLen)) begin
          fcount_d = '0;
          if (match_now && cfg_i.strip_enable) begin
            res.strip_valid  = 1'b1;
            res.strip_offset = cstart_wide[31:0];
            res.strip_size   = {1'b0, clen_q} + 33'(ChunkOvh);
          end
          if (match_now && cfg_i.capture_enable && !captured_q) begin
            captured_d = 1'b1;
            if (payload_len == 32'd0) begin
              phase_d = PH_SKIP;
              left_d  = 33'(CrcLen);
            end else begin
              phase_d = PH_PAYLOAD;
              left_d  = {1'b0, payload_len};
            end
          end else begin
            // rest of the data plus the CRC
            phase_d = PH_SKIP;
            left_d  = {1'b0, clen_q} - 33'(PfxLen - CrcLen);
          end
          match_d = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res.byte_class = CLS_PAYLOAD;
        left_d = left_dec;
        if (left_dec == 33'd0) begin
          phase_d = PH_SKIP;
          left_d  = 33'(CrcLen);
        end
      end
      PH_SKIP: begin
        res.byte_class = CLS_SKIP;
        left_d = left_dec;
        if (left_dec == 33'd0) begin
          phase_d  = PH_HEADER;
          fcount_d = '0;
        end
      end
      default: begin
        res.byte_class = CLS_IGNORED;
      end
    endcase

    if (phase_d == PH_DONE) begin
      res.parse_status = ST_DONE;
    end else if (phase_d == PH_ERROR) begin
      res.parse_status = ST_SIG_ERR;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SIG;
      fcount_q   <= '0;
      clen_q     <= '0;
      ctype_q    <= '0;
      match_q    <= 1'b1;
      left_q     <= '0;
      offset_q   <= '0;
      cstart_q   <= '0;
      captured_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      fcount_q   <= fcount_d;
      clen_q     <= clen_d;
      ctype_q    <= ctype_d;
      match_q    <= match_d;
      left_q     <= left_d;
      offset_q   <= offset_d;
      cstart_q   <= cstart_d;
      captured_q <= captured_d;
    end
  end

  `PXL_ASSERT_NEXT(a_error_sticky, phase_q == PH_ERROR, phase_q == PH_ERROR, "error phase left")
  `PXL_ASSERT_NOW(a_strip_at_prefix_end, res.strip_valid,
                  phase_q == PH_PREFIX && fcount_q == 5'(PfxLen - 1), "strip off prefix end")
  `PXL_ASSERT_NOW(a_payload_captured, phase_q == PH_PAYLOAD, captured_q,
                  "payload without capture flag")

endmodule

FILE: rtl/png_chunk_xmp_locator_core.sv
// Top level of the PNG XMP locator: byte stream in, one result per byte out.
// Depends on pngxmp_pkg, pngxmp_parser and png_chunk_xmp_locator_core_defines.svh.
//
//  Channel  | Dir | Signals                   | Carries
//  ---------+-----+---------------------------+----------------------------------------
//  s_axis   | in  | tvalid tready tdata[7:0]  | one PNG stream byte per transfer
//  m_axis   | out | tvalid tready tdata tuser | class, strip record, status per byte
//  apb      | in  | psel penable pwrite ...   | strip_enable @0x0, capture_enable @0x4
//
// One byte per cycle sustained while m_axis keeps accepting; each byte's result is formed
// combinationally in the parser logic and lands in the output register, or in the skid when m_axis stalls.
// A skid register behind the output register keeps s_axis ready for one
// extra transfer when m_axis stalls; ready drops only while the skid is full.
// Reset (asynchronous, active low) returns the parser to the signature check
// and restores both enables to 1.
`include "png_chunk_xmp_locator_core_defines.svh"

module png_chunk_xmp_locator_core #(
  parameter int unsigned OFFSET_BITS = pngxmp_pkg::OffsetBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // [31:0] strip_offset, [64:32] strip_size,
                                       // [66:65] parse_status, [71:67] zero
  output logic [3:0]  m_axis_tuser_o,  // [2:0] byte_class, [3] strip_valid
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pngxmp_pkg::*;

  cfg_t    cfg_q, cfg_d;
  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    s_xfer, out_free, cfg_wr;

  // ---- configuration port ----
  // Only paddr[2] decodes: register 0 at 0x0, register 1 at 0x4.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      if (paddr[2]) begin
        cfg_d.capture_enable = pwdata[0];
      end else begin
        cfg_d.strip_enable = pwdata[0];
      end
    end
  end

  assign prdata = paddr[2] ? {31'd0, cfg_q.capture_enable} : {31'd0, cfg_q.strip_enable};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{strip_enable: 1'b1, capture_enable: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---- parser ----
  assign s_axis_tready_o = !skid_valid_q;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  pngxmp_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s_xfer),
    .data_byte_i (s_axis_tdata_i),
    .cfg_i       (cfg_q),
    .result_o    (res)
  );

  // ---- output register with skid ----
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || s_xfer;
      skid_valid_q <= 1'b0;
    end else if (s_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (s_xfer) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.parse_status, out_q.strip_size, out_q.strip_offset};
  assign m_axis_tuser_o  = {out_q.strip_valid, out_q.byte_class};

  `PXL_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full, output empty")
  `PXL_ASSERT_NEXT(a_stall_fills_skid, out_valid_q && !m_axis_tready_i && s_xfer,
                   skid_valid_q, "stalled transfer not held in skid")
  `PXL_ASSERT_NEXT(a_skid_drains, skid_valid_q && m_axis_tready_i,
                   out_valid_q && !skid_valid_q, "skid did not drain")

endmodule
